### src/char_lcd_i2c_expander_sequencer_unit_assert.svh
// Assertion shorthands for the display sequencer checker.
`ifndef CHAR_LCD_I2C_EXPANDER_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_I2C_EXPANDER_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define LCDSEQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// next-cycle implication
`define LCDSEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

### src/lcdseq_pkg.sv
package lcdseq_pkg;

   typedef enum logic [2:0] {
      MODE_INIT      = 3'd0,
      MODE_CLEAR     = 3'd1,
      MODE_HOME      = 3'd2,
      MODE_CURSOR    = 3'd3,
      MODE_CHAR      = 3'd4,
      MODE_BACKLIGHT = 3'd5,
      MODE_PROBE     = 3'd6,
      MODE_RESPONSE  = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOINIT  = 2'd1,
      ST_NOACK   = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   localparam logic [2:0] REG_DEVICE_ADDRESS = 3'd0;
   localparam logic [2:0] REG_DATA_SHIFT     = 3'd1;
   localparam logic [2:0] REG_RS_PIN         = 3'd2;
   localparam logic [2:0] REG_EN_PIN         = 3'd3;
   localparam logic [2:0] REG_BL_PIN         = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   localparam logic [7:0] CMD_CLEAR   = 8'h01;
   localparam logic [7:0] CMD_HOME    = 8'h02;
   localparam logic [7:0] CMD_DDRAM   = 8'h80;
   localparam logic [6:0] ROW1_OFFSET = 7'h40;

   localparam logic [4:0] INIT_WRITES = 5'd24;
   localparam logic [4:0] BYTE_WRITES = 5'd4;
   localparam logic [4:0] ONE_WRITE   = 5'd1;

   localparam logic [14:0] WAIT_POWER_US  = 15'd20000;
   localparam logic [14:0] WAIT_STROBE_US = 15'd2;
   localparam logic [14:0] WAIT_FIRST_US  = 15'd5002;
   localparam logic [14:0] WAIT_NIBBLE_US = 15'd152;
   localparam logic [14:0] WAIT_LONG_US   = 15'd2000;
   localparam logic [14:0] WAIT_SHORT_US  = 15'd40;

   localparam logic [3:0] INIT_NIBBLES [4] = '{4'h3, 4'h3, 4'h3, 4'h2};
   localparam logic [7:0] INIT_BYTES   [4] = '{8'h28, 8'h0C, 8'h01, 8'h06};

   typedef struct packed {
      mode_type   mode;
      logic [7:0] row;
      logic [7:0] col;
      logic [7:0] char_code;
      logic [7:0] backlight_on;
      logic [7:0] probe_address;
      logic       nack;
   } req_type;

   typedef struct packed {
      logic        is_write;
      logic [7:0]  address_byte;
      logic        has_data;
      logic [7:0]  expander_byte;
      logic [14:0] wait_before_us;
      status_type  status;
      logic        ready_flag;
   } rsp_type;

   typedef struct packed {
      logic [2:0] data_shift;
      logic [2:0] rs_pin;
      logic [2:0] en_pin;
      logic [2:0] bl_pin;
   } pin_cfg_type;

   typedef struct packed {
      mode_type   op;
      logic [4:0] idx;
      logic [7:0] latched;
      logic       rs;
      logic       pending;
      logic       backlight;
   } emit_ctl_type;

   function automatic logic [7:0] pin_mask(input logic [2:0] p);
      return 8'b1 << p;
   endfunction

   function automatic logic [14:0] byte_delay(input logic [7:0] b);
      return (b == CMD_CLEAR || b == CMD_HOME) ? WAIT_LONG_US : WAIT_SHORT_US;
   endfunction

endpackage

### src/lcdseq_emit.sv
module lcdseq_emit (
   input  lcdseq_pkg::emit_ctl_type ctl,
   input  lcdseq_pkg::pin_cfg_type  pins,
   output logic [7:0]               exp_byte,
   output logic [14:0]              wait_us
);
   import lcdseq_pkg::*;

   logic [4:0] rel;
   logic [7:0] init_by;
   logic [7:0] prev_by;
   logic [3:0] nib;
   logic       rs;
   logic       en_high;
   logic [7:0] pins_v;
   logic [7:0] data_bits;

   assign rel     = ctl.idx - 5'd8;
   assign init_by = INIT_BYTES[rel[3:2]];
   assign prev_by = INIT_BYTES[rel[3:2] - 2'd1];

   always_comb begin
      case (ctl.op)
         MODE_INIT: begin
            rs = 1'b0;
            if (ctl.idx < 5'd8) begin
               nib     = INIT_NIBBLES[ctl.idx[2:1]];
               en_high = !ctl.idx[0];
            end else begin
               nib     = rel[1] ? init_by[3:0] : init_by[7:4];
               en_high = !rel[0];
            end
         end
         default: begin
            rs      = ctl.rs;
            nib     = ctl.idx[1] ? ctl.latched[3:0] : ctl.latched[7:4];
            en_high = !ctl.idx[0];
         end
      endcase
   end

   always_comb begin
      data_bits = {4'b0, nib} << pins.data_shift;
      pins_v    = (ctl.backlight ? pin_mask(pins.bl_pin) : 8'h00)
                | (rs ? pin_mask(pins.rs_pin) : 8'h00)
                | data_bits;
      case (ctl.op)
         MODE_BACKLIGHT: exp_byte = ctl.pending ? pin_mask(pins.bl_pin) : 8'h00;
         default: begin
            if (en_high) begin
               exp_byte = pins_v | pin_mask(pins.en_pin);
            end else begin
               exp_byte = pins_v & ~pin_mask(pins.en_pin);
            end
         end
      endcase
   end

   always_comb begin
      case (ctl.op)
         MODE_INIT: begin
            if (ctl.idx == 5'd0) begin
               wait_us = WAIT_POWER_US;
            end else if (ctl.idx[0]) begin
               wait_us = WAIT_STROBE_US;
            end else if (ctl.idx == 5'd2) begin
               wait_us = WAIT_FIRST_US;
            end else if (ctl.idx <= 5'd8) begin
               wait_us = WAIT_NIBBLE_US;
            end else if (rel[1:0] != 2'd0) begin
               wait_us = WAIT_STROBE_US;
            end else begin
               wait_us = WAIT_STROBE_US + byte_delay(prev_by);
            end
         end
         MODE_CLEAR, MODE_HOME, MODE_CURSOR, MODE_CHAR: begin
            if (ctl.idx == 5'd0) begin
               wait_us = '0;
            end else if (ctl.idx < 5'd4) begin
               wait_us = WAIT_STROBE_US;
            end else begin
               wait_us = WAIT_STROBE_US + byte_delay(ctl.latched);
            end
         end
         default: wait_us = '0;
      endcase
   end

endmodule

### src/char_lcd_i2c_expander_sequencer_unit.sv
// Character display sequencer for a 4-bit display controller behind an
// 8-bit bus port expander.
// Request channel (req_valid / req_stall / req_payload): a display command
// (init, clear, home, cursor, char, backlight, probe) or a bus response
// for the last write handed out. A command produces the first bus write of
// its sequence or an immediate completion; each acknowledged response
// produces the next write, and the last one a completion. A NACK ends the
// sequence with a no-ack completion.
// Response channel (rsp_valid / rsp_stall / rsp_payload): one write or
// completion per request that causes one, in order.
// The response is registered: valid in the cycle after its request is taken.
// Throughput: one request per cycle while req_stall is low; the decision is
// a single pass of logic between the request edge and the response register.
// When the receiver stalls, the response register holds and req_stall is
// raised only while a held response is still waiting.
// Reset (synchronous, active high) clears the sequencer, empties the
// response register and restores the pin map: data on bits 7..4, register
// select on bit 0, enable on bit 2, backlight on bit 3, no device address.
// Only write the csr port while the block is idle; it does not enforce this.
module char_lcd_i2c_expander_sequencer_unit #(
   parameter int MAX_COLUMN = 39
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  lcdseq_pkg::req_type                     req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output lcdseq_pkg::rsp_type                     rsp_payload,
   input  logic                                    csr_write_enable,
   input  logic [lcdseq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lcdseq_pkg::CSR_DATA_W-1:0]       csr_data
);
   import lcdseq_pkg::*;

   logic [6:0]   dev_addr_ff;
   pin_cfg_type  pins_ff;

   logic         busy_ff, busy_in;
   logic         ready_ff, ready_in;
   status_type   last_status_ff, last_status_in;
   logic         backlight_ff, backlight_in;
   logic         pending_ff, pending_in;
   mode_type     current_op_ff, current_op_in;
   logic [4:0]   step_ff, step_in;
   logic [7:0]   latched_ff, latched_in;
   logic         rs_ff, rs_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   emit_ctl_type ctl;
   logic [7:0]   emit_byte;
   logic [14:0]  emit_wait;
   logic [7:0]   cmd_byte;
   logic [6:0]   cursor_addr;
   logic [4:0]   step_next;
   logic [4:0]   total;
   logic         take;
   logic         has_result;
   logic         do_emit;
   logic         not_ready;
   status_type   gate_status;

   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign take        = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign step_next   = step_ff + 5'd1;
   assign cursor_addr = ((req_payload.row != 8'd0) ? ROW1_OFFSET : 7'h00)
                      + req_payload.col[6:0];

   always_comb begin
      case (req_payload.mode)
         MODE_CLEAR:  cmd_byte = CMD_CLEAR;
         MODE_HOME:   cmd_byte = CMD_HOME;
         MODE_CURSOR: cmd_byte = CMD_DDRAM | {1'b0, cursor_addr};
         MODE_CHAR:   cmd_byte = req_payload.char_code;
         default:     cmd_byte = latched_ff;
      endcase
   end

   always_comb begin
      case (current_op_ff)
         MODE_INIT:                                     total = INIT_WRITES;
         MODE_CLEAR, MODE_HOME, MODE_CURSOR, MODE_CHAR: total = BYTE_WRITES;
         default:                                       total = ONE_WRITE;
      endcase
   end

   always_comb begin
      ctl.backlight = backlight_ff;
      if (req_payload.mode == MODE_RESPONSE) begin
         ctl.op      = current_op_ff;
         ctl.idx     = step_next;
         ctl.latched = latched_ff;
         ctl.rs      = rs_ff;
         ctl.pending = pending_ff;
      end else begin
         ctl.op      = req_payload.mode;
         ctl.idx     = 5'd0;
         ctl.latched = cmd_byte;
         ctl.rs      = (req_payload.mode == MODE_CHAR);
         ctl.pending = req_payload.backlight_on[0];
      end
   end

   lcdseq_emit u_emit (
      .ctl      (ctl),
      .pins     (pins_ff),
      .exp_byte (emit_byte),
      .wait_us  (emit_wait)
   );

   always_comb begin
      not_ready = !ready_ff;
      if (last_status_ff == ST_NOACK || last_status_ff == ST_INVALID) begin
         gate_status = last_status_ff;
      end else begin
         gate_status = ST_NOINIT;
      end
   end

   always_comb begin
      busy_in        = busy_ff;
      ready_in       = ready_ff;
      last_status_in = last_status_ff;
      backlight_in   = backlight_ff;
      pending_in     = pending_ff;
      current_op_in  = current_op_ff;
      step_in        = step_ff;
      latched_in     = latched_ff;
      rs_in          = rs_ff;
      has_result     = 1'b0;
      do_emit        = 1'b0;
      rsp_in         = '0;
      rsp_in.status  = ST_OK;

      if (req_payload.mode == MODE_RESPONSE) begin
         if (busy_ff) begin
            has_result = 1'b1;
            if (req_payload.nack) begin
               if (current_op_ff != MODE_PROBE) begin
                  ready_in = 1'b0;
               end
               last_status_in = ST_NOACK;
               busy_in        = 1'b0;
               rsp_in.status  = ST_NOACK;
            end else begin
               last_status_in = ST_OK;
               step_in        = step_next;
               if (step_next >= total) begin
                  if (current_op_ff == MODE_INIT) begin
                     ready_in = 1'b1;
                  end
                  if (current_op_ff == MODE_BACKLIGHT) begin
                     backlight_in = pending_ff;
                  end
                  busy_in               = 1'b0;
                  rsp_in.wait_before_us = emit_wait;
               end else begin
                  do_emit = 1'b1;
               end
            end
         end
      end else if (!busy_ff) begin
         has_result = 1'b1;
         case (req_payload.mode)
            MODE_INIT: begin
               if (dev_addr_ff == 7'd0) begin
                  last_status_in = ST_NOINIT;
                  rsp_in.status  = ST_NOINIT;
               end else begin
                  ready_in       = 1'b0;
                  last_status_in = ST_OK;
                  current_op_in  = MODE_INIT;
                  step_in        = 5'd0;
                  do_emit        = 1'b1;
               end
            end
            MODE_PROBE: begin
               if (req_payload.probe_address == 8'd0 || req_payload.probe_address[7]) begin
                  last_status_in = ST_INVALID;
                  rsp_in.status  = ST_INVALID;
               end else begin
                  current_op_in       = MODE_PROBE;
                  step_in             = 5'd0;
                  busy_in             = 1'b1;
                  rsp_in.is_write     = 1'b1;
                  rsp_in.address_byte = {req_payload.probe_address[6:0], 1'b0};
               end
            end
            default: begin
               if (not_ready) begin
                  last_status_in = gate_status;
                  rsp_in.status  = gate_status;
               end else if ((req_payload.mode == MODE_CURSOR)
                            && (req_payload.row > 8'd1
                                || req_payload.col > 8'(MAX_COLUMN))) begin
                  last_status_in = ST_INVALID;
                  rsp_in.status  = ST_INVALID;
               end else if ((req_payload.mode == MODE_BACKLIGHT)
                            && req_payload.backlight_on > 8'd1) begin
                  last_status_in = ST_INVALID;
                  rsp_in.status  = ST_INVALID;
               end else if (req_payload.mode == MODE_BACKLIGHT) begin
                  current_op_in = MODE_BACKLIGHT;
                  step_in       = 5'd0;
                  pending_in    = req_payload.backlight_on[0];
                  do_emit       = 1'b1;
               end else begin
                  current_op_in = req_payload.mode;
                  step_in       = 5'd0;
                  latched_in    = cmd_byte;
                  rs_in         = (req_payload.mode == MODE_CHAR);
                  do_emit       = 1'b1;
               end
            end
         endcase
      end

      if (do_emit) begin
         rsp_in.wait_before_us = emit_wait;
         if (dev_addr_ff == 7'd0) begin
            last_status_in = ST_NOINIT;
            busy_in        = 1'b0;
            rsp_in.status  = ST_NOINIT;
         end else begin
            busy_in              = 1'b1;
            rsp_in.is_write      = 1'b1;
            rsp_in.address_byte  = {dev_addr_ff, 1'b0};
            rsp_in.has_data      = 1'b1;
            rsp_in.expander_byte = emit_byte;
         end
      end
      rsp_in.ready_flag = ready_in;

      if (take) begin
         rsp_valid_in = has_result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         ready_ff       <= 1'b0;
         last_status_ff <= ST_OK;
         backlight_ff   <= 1'b1;
         pending_ff     <= 1'b0;
         current_op_ff  <= MODE_INIT;
         step_ff        <= 5'd0;
         latched_ff     <= 8'd0;
         rs_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            busy_ff        <= busy_in;
            ready_ff       <= ready_in;
            last_status_ff <= last_status_in;
            backlight_ff   <= backlight_in;
            pending_ff     <= pending_in;
            current_op_ff  <= current_op_in;
            step_ff        <= step_in;
            latched_ff     <= latched_in;
            rs_ff          <= rs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff        <= 7'd0;
         pins_ff.data_shift <= 3'd4;
         pins_ff.rs_pin     <= 3'd0;
         pins_ff.en_pin     <= 3'd2;
         pins_ff.bl_pin     <= 3'd3;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DEVICE_ADDRESS: dev_addr_ff        <= csr_data;
            REG_DATA_SHIFT:     pins_ff.data_shift <= csr_data[2:0];
            REG_RS_PIN:         pins_ff.rs_pin     <= csr_data[2:0];
            REG_EN_PIN:         pins_ff.en_pin     <= csr_data[2:0];
            REG_BL_PIN:         pins_ff.bl_pin     <= csr_data[2:0];
            default: ;
         endcase
      end
   end

endmodule

### src/lcdseq_checker.sv
`include "char_lcd_i2c_expander_sequencer_unit_assert.svh"

module lcdseq_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input lcdseq_pkg::rsp_type rsp_payload
);
   import lcdseq_pkg::*;

   logic wr_seen;
   logic done_seen;
   logic probe_seen;
   logic write_ok;
   logic empty_fields;
   logic probe_quiet;

   assign wr_seen      = rsp_valid && rsp_payload.is_write;
   assign done_seen    = rsp_valid && !rsp_payload.is_write;
   assign probe_seen   = wr_seen && !rsp_payload.has_data;
   assign write_ok     = (rsp_payload.status == ST_OK) && !rsp_payload.address_byte[0];
   assign empty_fields = (rsp_payload.address_byte == 8'd0) && !rsp_payload.has_data
                       && (rsp_payload.expander_byte == 8'd0);
   assign probe_quiet  = (rsp_payload.expander_byte == 8'd0)
                       && (rsp_payload.wait_before_us == 15'd0);

   `LCDSEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `LCDSEQ_ASSERT_NOW(a_no_stall_when_empty, !rsp_valid, !req_stall)
   `LCDSEQ_ASSERT_NOW(a_write_status_ok, wr_seen, write_ok)
   `LCDSEQ_ASSERT_NOW(a_done_is_empty, done_seen, empty_fields)
   `LCDSEQ_ASSERT_NOW(a_probe_write, probe_seen, probe_quiet)

endmodule

bind char_lcd_i2c_expander_sequencer_unit lcdseq_checker u_lcdseq_checker (.*);
